>>> rtl/rth_pkg.sv
// Package for the RGB-to-hue converter: field widths, defaults and sector codes.
// Depends on nothing; imported by rgb_to_hue.
`default_nettype none

package rth_pkg;

  // Width of one color channel.
  localparam int unsigned ChanW = 8;
  // Width of the hue result field and of its padded stream beat.
  localparam int unsigned HueW = 15;
  localparam int unsigned OutDataW = 16;
  // Three channels packed in the input beat.
  localparam int unsigned InDataW = 3 * ChanW;

  // Default number of fractional hue bits.
  localparam int unsigned FracBitsDefault = 6;

  // Scaled hue numerator: below 360 * 255, so 17 bits.
  localparam int unsigned NumW = 17;
  // Signed working width for the numerator before the wrap.
  localparam int unsigned SumW = 20;
  // Integer bits of the quotient: hue degrees below 512.
  localparam int unsigned QuoIntW = 9;

  // Which channel holds the largest value.
  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

endpackage

`default_nettype wire

>>> rtl/rgb_to_hue.sv
// RGB-to-hue converter: top level with the sector stage, the numerator stage
// and a one-bit-per-stage restoring divider. Depends on rth_pkg.
`default_nettype none

// Usage:
// Input beats arrive on s_axis_* with blue in tdata[7:0], green in [15:8]
// and red in [23:16]. Each beat gives exactly one output beat on m_axis_*
// carrying the hue in degrees times 2^FRAC_BITS (floor) in tdata[14:0].
// In the pipeline, one stage finds the largest channel and the range, one
// forms the scaled numerator and its wrap, and FRAC_BITS + 9 stages each
// produce one quotient bit of the division by the range.
// Throughput is one beat per clock while the receiver does not stall; a new
// beat may enter on every cycle unless the output is held.
// When the receiver stalls with a result waiting at the output, the whole
// pipeline holds and s_axis_tready drops in the same cycle; nothing is lost
// or repeated, and the pipeline resumes as soon as m_axis_tready is high.
// Reset clears all stage valid flags, so the pipeline comes up empty.
// A gray pixel (all channels equal) gives a hue of 0.
module rgb_to_hue #(
  parameter int unsigned FRAC_BITS = rth_pkg::FracBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input beat fields, low bit up: blue[7:0], green[15:8], red[23:16].
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [rth_pkg::InDataW-1:0]  s_axis_tdata,
  // Output beat fields, low bit up: hue[14:0], zero pad[15].
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [rth_pkg::OutDataW-1:0] m_axis_tdata
);
  import rth_pkg::*;

  // Quotient width and total number of divider stages.
  localparam int unsigned QuoW = QuoIntW + FRAC_BITS;

  // Pipeline advance: move when the output slot is empty or being taken.
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------------
  // Stage 1: largest channel, range and the signed channel difference.
  // ---------------------------------------------------------------------
  logic [ChanW-1:0] in_b, in_g, in_r;
  logic [ChanW-1:0] hi, lo;
  sector_e          sec_d;
  logic signed [ChanW:0] diff_d;

  assign in_b = s_axis_tdata[ChanW-1:0];
  assign in_g = s_axis_tdata[2*ChanW-1:ChanW];
  assign in_r = s_axis_tdata[3*ChanW-1:2*ChanW];

  always_comb begin
    // Red wins ties over green, green over blue.
    if (in_r >= in_g && in_r >= in_b) begin
      sec_d  = SecRed;
      hi     = in_r;
      diff_d = $signed({1'b0, in_g}) - $signed({1'b0, in_b});
    end else if (in_g >= in_b) begin
      sec_d  = SecGreen;
      hi     = in_g;
      diff_d = $signed({1'b0, in_b}) - $signed({1'b0, in_r});
    end else begin
      sec_d  = SecBlue;
      hi     = in_b;
      diff_d = $signed({1'b0, in_r}) - $signed({1'b0, in_g});
    end
    lo = in_r;
    if (in_g < lo) begin
      lo = in_g;
    end
    if (in_b < lo) begin
      lo = in_b;
    end
  end

  logic                  v1_q;
  sector_e               sec_q;
  logic [ChanW-1:0]      rng_q;
  logic signed [ChanW:0] diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec_q  <= sec_d;
      rng_q  <= hi - lo;
      diff_q <= diff_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: numerator T = base * range + 60 * diff, wrapped when negative.
  // ---------------------------------------------------------------------
  logic [SumW-1:0]        base_term;
  logic signed [SumW-1:0] diff_x;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] wrapped;
  logic [NumW-1:0]        num;
  logic                   gray;

  always_comb begin
    case (sec_q)
      SecGreen: base_term = SumW'(rng_q) * SumW'(120);
      SecBlue:  base_term = SumW'(rng_q) * SumW'(240);
      default:  base_term = '0;
    endcase
    diff_x  = SumW'(diff_q);
    sum     = $signed(base_term) + diff_x * $signed(SumW'(60));
    wrapped = sum;
    if (sum < 0) begin
      wrapped = sum + $signed(SumW'(rng_q) * SumW'(360));
    end
    gray = (rng_q == '0);
    num  = gray ? '0 : wrapped[NumW-1:0];
  end

  // Divider state per stage: partial remainder, numerator/quotient shift
  // word and divisor. Index 0 is loaded here, index QuoW holds the result.
  logic             vd_q   [QuoW+1];
  logic [ChanW-1:0] rem_q  [QuoW+1];
  logic [QuoW-1:0]  nq_q   [QuoW+1];
  logic [ChanW-1:0] dvs_q  [QuoW+1];

  // The top eight numerator bits are always below the divisor.
  logic [ChanW-1:0] rem_init;
  logic [QuoW-1:0]  nq_init;
  logic [ChanW-1:0] dvs_init;

  assign rem_init = num[NumW-1:QuoIntW];
  assign nq_init  = QuoW'(num[QuoIntW-1:0]) << FRAC_BITS;
  assign dvs_init = gray ? ChanW'(1) : rng_q;

  // ---------------------------------------------------------------------
  // Divider stages: one restoring step per stage.
  // ---------------------------------------------------------------------
  logic [ChanW-1:0] rem_d [QuoW];
  logic [QuoW-1:0]  nq_d  [QuoW];

  always_comb begin
    for (int k = 0; k < QuoW; k++) begin
      logic [ChanW:0] part;
      logic           ge;
      part     = {rem_q[k], nq_q[k][QuoW-1]};
      ge       = (part >= {1'b0, dvs_q[k]});
      rem_d[k] = ge ? ChanW'(part - {1'b0, dvs_q[k]}) : part[ChanW-1:0];
      nq_d[k]  = {nq_q[k][QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QuoW; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vd_q[0] <= v1_q;
      for (int k = 0; k < QuoW; k++) begin
        vd_q[k+1] <= vd_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= rem_init;
      nq_q[0]  <= nq_init;
      dvs_q[0] <= dvs_init;
      for (int k = 0; k < QuoW; k++) begin
        rem_q[k+1] <= rem_d[k];
        nq_q[k+1]  <= nq_d[k];
        dvs_q[k+1] <= dvs_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output: the last divider stage is the output register.
  // ---------------------------------------------------------------------
  logic [HueW+QuoW-1:0] quo_ext;

  assign quo_ext       = {{HueW{1'b0}}, nq_q[QuoW]};
  assign m_axis_tvalid = vd_q[QuoW];
  assign m_axis_tdata  = OutDataW'(quo_ext[HueW-1:0]);

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for rgb_to_hue: drives pixels on the input stream and
// compares each output hue against a predictor kept in a small scoreboard class.
// Depends on rth_pkg and rgb_to_hue.
`timescale 1ns / 100ps

module tb_top;
  import rth_pkg::*;

  localparam int unsigned FracBits = FracBitsDefault;
  localparam int unsigned RandPixels = 1750;
  // Items sent back to back; the receiver still stalls at random.
  localparam int unsigned BurstFirst = 250;
  localparam int unsigned BurstLast = 450;
  // Items during which neither side idles.
  localparam int unsigned CalmFirst = 1000;
  localparam int unsigned CalmLast = 1200;
  localparam int unsigned HoldAtResult = 260;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned DrainCycles = 40;

  // Holds the expected hues in arrival order and checks each output beat.
  class hue_scoreboard;
    logic [HueW-1:0] pending_hues[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Hue in degrees times 2^FracBits, floor, kept to the field width.
    function automatic logic [HueW-1:0] predict_hue(logic [ChanW-1:0] b,
                                                    logic [ChanW-1:0] g,
                                                    logic [ChanW-1:0] r);
      int hi, lo, d, t;
      longint unsigned q;
      hi = int'(r);
      if (int'(g) > hi) hi = int'(g);
      if (int'(b) > hi) hi = int'(b);
      lo = int'(r);
      if (int'(g) < lo) lo = int'(g);
      if (int'(b) < lo) lo = int'(b);
      d = hi - lo;
      // Gray pixels have no defined hue and give zero.
      if (d == 0) return '0;
      // Red wins ties for the largest channel, then green.
      if (hi == int'(r)) t = 60 * (int'(g) - int'(b));
      else if (hi == int'(g)) t = 120 * d + 60 * (int'(b) - int'(r));
      else t = 240 * d + 60 * (int'(r) - int'(g));
      if (t < 0) t = t + 360 * d;
      q = longint'(t);
      q = (q << FracBits) / longint'(d);
      return q[HueW-1:0];
    endfunction

    function void note_pixel(logic [ChanW-1:0] b, logic [ChanW-1:0] g,
                             logic [ChanW-1:0] r);
      pending_hues.insert(pending_hues.size(), predict_hue(b, g, r));
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_hue(logic [HueW-1:0] got);
      logic [HueW-1:0] want;
      if (pending_hues.size() == 0) begin
        report_mismatch($sformatf("hue %0d arrived with nothing expected", got));
      end else begin
        want = pending_hues.pop_front();
        if (got !== want)
          report_mismatch($sformatf("hue %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  hue_scoreboard hue_sb;
  int unsigned   pixels_sent;
  int unsigned   hues_seen;
  bit            calm_phase;
  bit            burst_phase;

  rgb_to_hue #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock, 8 ns period.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Offers a pixel after a random gap (none in burst or calm); waits until taken.
  task send_pixel(logic [ChanW-1:0] b, logic [ChanW-1:0] g, logic [ChanW-1:0] r);
    int unsigned gap;
    gap = (calm_phase || burst_phase) ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, g, b};
    do @(posedge clk_i); while (!s_axis_tready);
    hue_sb.note_pixel(b, g, r);
    pixels_sent++;
  endtask

  // Random pixel: mostly uniform, some with tied maxima, some with tiny ranges.
  task send_random_pixel();
    logic [ChanW-1:0] b, g, r, base;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    b = ChanW'($urandom_range(0, 255));
    g = ChanW'($urandom_range(0, 255));
    r = ChanW'($urandom_range(0, 255));
    if (pick < 2) begin
      // Two or three channels share the largest value.
      base = ChanW'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: begin r = base; g = base; end
        1: begin g = base; b = base; end
        2: begin r = base; b = base; end
        default: begin r = base; g = base; b = base; end
      endcase
      if (b > base) b = base;
      if (g > base) g = base;
      if (r > base) r = base;
    end else if (pick < 4) begin
      // Channels within a few codes of each other.
      base = ChanW'($urandom_range(0, 252));
      b = base + ChanW'($urandom_range(0, 3));
      g = base + ChanW'($urandom_range(0, 3));
      r = base + ChanW'($urandom_range(0, 3));
    end
    send_pixel(b, g, r);
  endtask

  // Reset, directed pixels, random pixels, then drain and verdict.
  initial begin
    hue_sb = new();
    pixels_sent = 0;
    calm_phase = 1'b0;
    burst_phase = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Gray pixels at both ends and in the middle.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    // Pure primaries, one per sector.
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    // Ties for the largest channel.
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd17, 8'd200, 8'd200);
    // Red largest with blue above green: negative hue that wraps.
    send_pixel(8'd10, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd254, 8'd0, 8'd255);
    // Range of one in each sector.
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd255);
    // Blue largest (negative term when red is below green), then green largest.
    send_pixel(8'd255, 8'd200, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd200);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd0, 8'd170, 8'd85);

    for (int unsigned i = 0; i < RandPixels; i++) begin
      burst_phase = (i >= BurstFirst) && (i < BurstLast);
      calm_phase = (i >= CalmFirst) && (i < CalmLast);
      send_random_pixel();
    end
    calm_phase = 1'b0;
    burst_phase = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (hue_sb.pending_hues.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (hue_sb.pending_hues.size() > 0)
      hue_sb.report_mismatch("expected hues left over at the end");
    if (hue_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls per beat unless calm, long hold to back pipeline up.
  initial begin
    int unsigned gap;
    bit held;
    hues_seen = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && hues_seen == HoldAtResult) begin
        gap = HoldCycles;
        held = 1'b1;
      end else begin
        gap = calm_phase ? 0 : $urandom_range(0, 6);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      hue_sb.check_hue(m_axis_tdata[HueW-1:0]);
      hues_seen++;
    end
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
